// ===== sv/lsgf_pkg.sv =====
// lsgf_pkg: shared constants for the lidar scan gap finder
// holds sizes, field widths, register indexes and register reset values
// no dependencies
`default_nettype none

package lsgf_pkg;

  // sizing
  localparam int MAX_WINDOW = 16;
  localparam int MAX_SCAN   = 1024;

  // field widths
  localparam int RANGE_W = 17;
  localparam int IDX_W   = $clog2(MAX_SCAN);
  localparam int LEN_W   = IDX_W + 1;
  localparam int AWIN_W  = 5;
  localparam int SLEN_W  = 11;
  localparam int START_W = 16;
  localparam int STEP_W  = 10;
  localparam int ANG_W   = 21;

  // window and divider widths
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int LINE_IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W   = RANGE_W + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 0);
  localparam int ALU_W   = SUM_W + 1;
  localparam int DIV_CW  = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  // angle arithmetic widths
  localparam int PROD_W  = IDX_W + STEP_W;
  localparam int AMAX_W  = (PROD_W > ANG_W) ? PROD_W : ANG_W;
  localparam int ASUM_W  = AMAX_W + 2;
  localparam int ANG_MAX_I = (1 << (ANG_W - 1)) - 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_AVG_WINDOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LENGTH = 3'd5;

  // register reset values
  localparam logic [AWIN_W-1:0]         AVG_WINDOW_RST  = 5'd0;
  localparam logic [RANGE_W-1:0]        CLAMP_LIMIT_RST = 17'd100000;
  localparam logic [RANGE_W-1:0]        GAP_LEVEL_RST   = 17'd3000;
  localparam logic signed [START_W-1:0] ANGLE_START_RST = -16'sd23562;
  localparam logic [STEP_W-1:0]         ANGLE_STEP_RST  = 10'd44;
  localparam logic [SLEN_W-1:0]         SCAN_LENGTH_RST = 11'd1024;

endpackage

`default_nettype wire

// ===== sv/lsgf_ram.sv =====
// lsgf_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module lsgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/lidar_scan_gap_finder.sv =====
// lidar_scan_gap_finder: moving average, clamp and longest-gap search over a lidar scan
// depends on lsgf_pkg and lsgf_ram
//
// usage
//   input channel (in_valid_i / in_stall_o) takes one range sample per transaction,
//   with an invalid flag. the block smooths it over avg_window samples, clamps it,
//   stores it and returns one result transaction per sample on the output channel
//   (out_valid_o / out_stall_i). on the last sample of a scan the result also
//   carries the longest gap, its midpoint, the stored range there and its angle.
//   configuration is a separate write channel (cfg_valid_i / cfg_ready_o, always
//   ready); the user must write it only while the block is idle, the block does not enforce it.
// sequence
//   one sample at a time through a small sequencer around one shared adder.
//   with averaging: take the sample, sum the N newest window entries (N = samples in
//   the window, up to 16), bit-serial divide by the window count, clamp and store, output.
//   without averaging the sum and divide are skipped. the last sample of a scan that
//   found a gap adds the midpoint lookup, multiply and saturation steps.
// reset and stall
//   reset clears the registers, the window line and the scan position; the scan
//   store needs no clearing. a result waits in the output register while the
//   receiver stalls; the next sample is accepted meanwhile and held at its end.
`default_nettype none

module lidar_scan_gap_finder (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // sample input
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [lsgf_pkg::RANGE_W-1:0]           range_mm_i,
  input  wire logic                                   range_invalid_i,
  // result output
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic [lsgf_pkg::RANGE_W-1:0]                filtered_mm_o,
  output logic [lsgf_pkg::IDX_W-1:0]                  sample_index_o,
  output logic                                        scan_done_o,
  output logic                                        gap_found_o,
  output logic [lsgf_pkg::IDX_W-1:0]                  gap_first_o,
  output logic [lsgf_pkg::IDX_W-1:0]                  gap_last_o,
  output logic [lsgf_pkg::IDX_W-1:0]                  target_index_o,
  output logic [lsgf_pkg::RANGE_W-1:0]                target_range_mm_o,
  output logic signed [lsgf_pkg::ANG_W-1:0]           target_angle_o,
  // configuration writes
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [lsgf_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [lsgf_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_CLAMP,
    S_TGT,
    S_ANG,
    S_SAT,
    S_OUT
  } state_e;

  localparam logic signed [lsgf_pkg::ASUM_W-1:0] ANG_HI =
    lsgf_pkg::ASUM_W'(lsgf_pkg::ANG_MAX_I);
  localparam logic signed [lsgf_pkg::ASUM_W-1:0] ANG_LO = ~ANG_HI;

  state_e state_q;

  // configuration registers
  logic [lsgf_pkg::AWIN_W-1:0]         avg_window_q;
  logic [lsgf_pkg::RANGE_W-1:0]        clamp_q;
  logic [lsgf_pkg::RANGE_W-1:0]        gap_level_q;
  logic signed [lsgf_pkg::START_W-1:0] angle_start_q;
  logic [lsgf_pkg::STEP_W-1:0]         angle_step_q;
  logic [lsgf_pkg::SLEN_W-1:0]         scan_length_q;

  // per-item working registers
  logic [lsgf_pkg::RANGE_W-1:0] line_q [lsgf_pkg::MAX_WINDOW];
  logic [lsgf_pkg::RANGE_W-1:0] raw_q;
  logic                         inv_q;
  logic [lsgf_pkg::CNT_W-1:0]   cnt_q;
  logic [lsgf_pkg::LINE_IW-1:0] k_q;
  logic [lsgf_pkg::SUM_W-1:0]   acc_q;
  logic [lsgf_pkg::SUM_W-1:0]   dvd_q;
  logic [lsgf_pkg::CNT_W-1:0]   rem_q;
  logic [lsgf_pkg::DIV_CW-1:0]  bit_q;
  logic [lsgf_pkg::RANGE_W-1:0] filt_q;

  // scan state
  logic [lsgf_pkg::IDX_W-1:0]   sample_count_q;
  logic [lsgf_pkg::LEN_W-1:0]   run_q;
  logic [lsgf_pkg::LEN_W-1:0]   best_len_q;
  logic [lsgf_pkg::IDX_W-1:0]   best_end_q;

  // result staging
  logic [lsgf_pkg::RANGE_W-1:0] res_filt_q;
  logic [lsgf_pkg::IDX_W-1:0]   res_idx_q;
  logic                         res_done_q;
  logic                         res_found_q;
  logic [lsgf_pkg::IDX_W-1:0]   gap_first_q;
  logic [lsgf_pkg::IDX_W-1:0]   gap_last_q;
  logic [lsgf_pkg::IDX_W-1:0]   tgt_q;
  logic [lsgf_pkg::PROD_W-1:0]  prod_q;
  logic [lsgf_pkg::RANGE_W-1:0] trange_q;
  logic signed [lsgf_pkg::ANG_W-1:0] ang_q;

  // output register
  logic                              out_valid_q;
  logic [lsgf_pkg::RANGE_W-1:0]      out_filt_q;
  logic [lsgf_pkg::IDX_W-1:0]        out_idx_q;
  logic                              out_done_q;
  logic                              out_found_q;
  logic [lsgf_pkg::IDX_W-1:0]        out_first_q;
  logic [lsgf_pkg::IDX_W-1:0]        out_last_q;
  logic [lsgf_pkg::IDX_W-1:0]        out_tgt_q;
  logic [lsgf_pkg::RANGE_W-1:0]      out_trange_q;
  logic signed [lsgf_pkg::ANG_W-1:0] out_ang_q;

  // effective window and scan length
  logic [lsgf_pkg::LEN_W-1:0] len_eff_c;
  logic [lsgf_pkg::CNT_W-1:0] win_sat_c;
  logic [lsgf_pkg::CNT_W-1:0] win_eff_c;
  logic [31:0]                idx_inc_c;
  logic [lsgf_pkg::CNT_W-1:0] cnt_c;

  always_comb begin
    if (scan_length_q == '0) begin
      len_eff_c = lsgf_pkg::LEN_W'(1);
    end else if (32'(scan_length_q) > 32'(lsgf_pkg::MAX_SCAN)) begin
      len_eff_c = lsgf_pkg::LEN_W'(lsgf_pkg::MAX_SCAN);
    end else begin
      len_eff_c = lsgf_pkg::LEN_W'(scan_length_q);
    end
    if (32'(avg_window_q) > 32'(lsgf_pkg::MAX_WINDOW)) begin
      win_sat_c = lsgf_pkg::CNT_W'(lsgf_pkg::MAX_WINDOW);
    end else begin
      win_sat_c = lsgf_pkg::CNT_W'(avg_window_q);
    end
    win_eff_c = (32'(len_eff_c) < 32'(win_sat_c)) ? '0 : win_sat_c;
    idx_inc_c = 32'(sample_count_q) + 32'd1;
    cnt_c = (idx_inc_c < 32'(win_eff_c)) ? lsgf_pkg::CNT_W'(idx_inc_c) : win_eff_c;
  end

  // shared adder: window accumulation and divider trial subtract
  logic [lsgf_pkg::ALU_W-1:0] alu_a_c;
  logic [lsgf_pkg::ALU_W-1:0] alu_b_c;
  logic                       alu_sub_c;
  logic [lsgf_pkg::ALU_W-1:0] alu_res_c;
  logic [lsgf_pkg::CNT_W:0]   rem_next_c;

  assign rem_next_c = {rem_q, dvd_q[lsgf_pkg::SUM_W-1]};

  always_comb begin
    if (state_q == S_DIV) begin
      alu_a_c   = lsgf_pkg::ALU_W'(rem_next_c);
      alu_b_c   = lsgf_pkg::ALU_W'(cnt_q);
      alu_sub_c = 1'b1;
    end else begin
      alu_a_c   = lsgf_pkg::ALU_W'(acc_q);
      alu_b_c   = lsgf_pkg::ALU_W'(line_q[k_q]);
      alu_sub_c = 1'b0;
    end
    alu_res_c = alu_a_c + (alu_sub_c ? ~alu_b_c : alu_b_c) + lsgf_pkg::ALU_W'(alu_sub_c);
  end

  // divider step
  logic                       div_neg_c;
  logic [lsgf_pkg::CNT_W-1:0] rem_d;
  logic [lsgf_pkg::SUM_W-1:0] dvd_d;

  assign div_neg_c = alu_res_c[lsgf_pkg::ALU_W-1];
  assign rem_d = div_neg_c ? rem_next_c[lsgf_pkg::CNT_W-1:0]
                           : alu_res_c[lsgf_pkg::CNT_W-1:0];
  assign dvd_d = {dvd_q[lsgf_pkg::SUM_W-2:0], ~div_neg_c};

  // clamp, gap run update and gap bounds
  logic [lsgf_pkg::RANGE_W-1:0] filt_c;
  logic                         above_c;
  logic [lsgf_pkg::LEN_W-1:0]   run_inc_c;
  logic                         better_c;
  logic [lsgf_pkg::LEN_W-1:0]   best_len_c;
  logic [lsgf_pkg::IDX_W-1:0]   best_end_c;
  logic                         done_c;
  logic [lsgf_pkg::LEN_W-1:0]   first_c;
  logic [lsgf_pkg::LEN_W-1:0]   tgt_sum_c;
  logic [lsgf_pkg::IDX_W-1:0]   tgt_c;

  always_comb begin
    filt_c     = (inv_q || (filt_q > clamp_q)) ? clamp_q : filt_q;
    above_c    = filt_c > gap_level_q;
    run_inc_c  = run_q + lsgf_pkg::LEN_W'(1);
    better_c   = above_c && (run_inc_c > best_len_q);
    best_len_c = better_c ? run_inc_c : best_len_q;
    best_end_c = better_c ? sample_count_q : best_end_q;
    done_c     = {1'b0, sample_count_q} >= (len_eff_c - lsgf_pkg::LEN_W'(1));
    first_c    = {1'b0, best_end_c} + lsgf_pkg::LEN_W'(1) - best_len_c;
    tgt_sum_c  = {1'b0, gap_first_q} + {1'b0, gap_last_q};
    tgt_c      = tgt_sum_c[lsgf_pkg::LEN_W-1:1];
  end

  // angle sum and saturation
  logic signed [lsgf_pkg::ASUM_W-1:0] start_x_c;
  logic signed [lsgf_pkg::ASUM_W-1:0] prod_x_c;
  logic signed [lsgf_pkg::ASUM_W-1:0] asum_c;
  logic signed [lsgf_pkg::ASUM_W-1:0] asat_c;

  always_comb begin
    start_x_c = lsgf_pkg::ASUM_W'(angle_start_q);
    prod_x_c  = lsgf_pkg::ASUM_W'(prod_q);
    asum_c    = start_x_c + prod_x_c;
    if (asum_c > ANG_HI) begin
      asat_c = ANG_HI;
    end else if (asum_c < ANG_LO) begin
      asat_c = ANG_LO;
    end else begin
      asat_c = asum_c;
    end
  end

  // scan store
  logic                         ram_we_c;
  logic                         ram_re_c;
  logic [lsgf_pkg::RANGE_W-1:0] ram_rdata;

  assign ram_we_c = (state_q == S_CLAMP);
  assign ram_re_c = (state_q == S_TGT);

  lsgf_ram #(
    .WIDTH (lsgf_pkg::RANGE_W),
    .DEPTH (lsgf_pkg::MAX_SCAN)
  ) u_scan_store (
    .clk_i   (clk_i),
    .we_i    (ram_we_c),
    .waddr_i (sample_count_q),
    .wdata_i (filt_c),
    .re_i    (ram_re_c),
    .raddr_i (tgt_c),
    .rdata_o (ram_rdata)
  );

  // handshakes
  logic in_take_c;
  logic out_free_c;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_take_c   = in_valid_i && (state_q == S_IDLE);
  assign out_free_c  = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // sequencer, working registers and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      avg_window_q   <= lsgf_pkg::AVG_WINDOW_RST;
      clamp_q        <= lsgf_pkg::CLAMP_LIMIT_RST;
      gap_level_q    <= lsgf_pkg::GAP_LEVEL_RST;
      angle_start_q  <= lsgf_pkg::ANGLE_START_RST;
      angle_step_q   <= lsgf_pkg::ANGLE_STEP_RST;
      scan_length_q  <= lsgf_pkg::SCAN_LENGTH_RST;
      for (int i = 0; i < lsgf_pkg::MAX_WINDOW; i++) begin
        line_q[i] <= '0;
      end
      raw_q          <= '0;
      inv_q          <= 1'b0;
      cnt_q          <= '0;
      k_q            <= '0;
      acc_q          <= '0;
      dvd_q          <= '0;
      rem_q          <= '0;
      bit_q          <= '0;
      filt_q         <= '0;
      sample_count_q <= '0;
      run_q          <= '0;
      best_len_q     <= '0;
      best_end_q     <= '0;
      res_filt_q     <= '0;
      res_idx_q      <= '0;
      res_done_q     <= 1'b0;
      res_found_q    <= 1'b0;
      gap_first_q    <= '0;
      gap_last_q     <= '0;
      tgt_q          <= '0;
      prod_q         <= '0;
      trange_q       <= '0;
      ang_q          <= '0;
      out_valid_q    <= 1'b0;
      out_filt_q     <= '0;
      out_idx_q      <= '0;
      out_done_q     <= 1'b0;
      out_found_q    <= 1'b0;
      out_first_q    <= '0;
      out_last_q     <= '0;
      out_tgt_q      <= '0;
      out_trange_q   <= '0;
      out_ang_q      <= '0;
    end else begin
      // configuration writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          lsgf_pkg::CFG_AVG_WINDOW:  avg_window_q  <= cfg_data_i[lsgf_pkg::AWIN_W-1:0];
          lsgf_pkg::CFG_CLAMP_LIMIT: clamp_q       <= cfg_data_i[lsgf_pkg::RANGE_W-1:0];
          lsgf_pkg::CFG_GAP_LEVEL:   gap_level_q   <= cfg_data_i[lsgf_pkg::RANGE_W-1:0];
          lsgf_pkg::CFG_ANGLE_START: angle_start_q <= cfg_data_i[lsgf_pkg::START_W-1:0];
          lsgf_pkg::CFG_ANGLE_STEP:  angle_step_q  <= cfg_data_i[lsgf_pkg::STEP_W-1:0];
          lsgf_pkg::CFG_SCAN_LENGTH: scan_length_q <= cfg_data_i[lsgf_pkg::SLEN_W-1:0];
          default: ;
        endcase
      end

      // output register drains
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        // take a sample and shift it into the window line
        S_IDLE: begin
          if (in_take_c) begin
            for (int i = lsgf_pkg::MAX_WINDOW - 1; i > 0; i--) begin
              line_q[i] <= line_q[i-1];
            end
            line_q[0] <= range_invalid_i ? clamp_q : range_mm_i;
            raw_q     <= range_mm_i;
            inv_q     <= range_invalid_i;
            cnt_q     <= cnt_c;
            k_q       <= '0;
            acc_q     <= '0;
            filt_q    <= range_mm_i;
            state_q   <= (win_eff_c == '0) ? S_CLAMP : S_SUM;
          end
        end

        // accumulate the newest cnt entries, one per cycle
        S_SUM: begin
          if (32'(k_q) + 32'd1 == 32'(cnt_q)) begin
            dvd_q   <= alu_res_c[lsgf_pkg::SUM_W-1:0];
            rem_q   <= '0;
            bit_q   <= lsgf_pkg::DIV_CW'(lsgf_pkg::SUM_W - 1);
            state_q <= S_DIV;
          end else begin
            acc_q <= alu_res_c[lsgf_pkg::SUM_W-1:0];
            k_q   <= k_q + lsgf_pkg::LINE_IW'(1);
          end
        end

        // restoring divide by the window count, one quotient bit per cycle
        S_DIV: begin
          dvd_q <= dvd_d;
          rem_q <= rem_d;
          bit_q <= bit_q - lsgf_pkg::DIV_CW'(1);
          if (bit_q == '0) begin
            filt_q  <= dvd_d[lsgf_pkg::RANGE_W-1:0];
            state_q <= S_CLAMP;
          end
        end

        // clamp, store, track the longest gap
        S_CLAMP: begin
          res_filt_q  <= filt_c;
          res_idx_q   <= sample_count_q;
          res_done_q  <= done_c;
          res_found_q <= done_c && (best_len_c != '0);
          gap_first_q <= '0;
          gap_last_q  <= '0;
          tgt_q       <= '0;
          trange_q    <= '0;
          ang_q       <= '0;
          if (done_c) begin
            sample_count_q <= '0;
            run_q          <= '0;
            best_len_q     <= '0;
            best_end_q     <= '0;
            if (best_len_c != '0) begin
              gap_first_q <= first_c[lsgf_pkg::IDX_W-1:0];
              gap_last_q  <= best_end_c;
              state_q     <= S_TGT;
            end else begin
              state_q     <= S_OUT;
            end
          end else begin
            sample_count_q <= sample_count_q + lsgf_pkg::IDX_W'(1);
            run_q          <= above_c ? run_inc_c : '0;
            best_len_q     <= best_len_c;
            best_end_q     <= best_end_c;
            state_q        <= S_OUT;
          end
        end

        // midpoint, store read issued
        S_TGT: begin
          tgt_q   <= tgt_c;
          state_q <= S_ANG;
        end

        // angle product, stored range captured
        S_ANG: begin
          prod_q   <= lsgf_pkg::PROD_W'(tgt_q) * lsgf_pkg::PROD_W'(angle_step_q);
          trange_q <= ram_rdata;
          state_q  <= S_SAT;
        end

        // angle offset and saturation
        S_SAT: begin
          ang_q   <= asat_c[lsgf_pkg::ANG_W-1:0];
          state_q <= S_OUT;
        end

        // hand the result to the output register once it is free
        S_OUT: begin
          if (out_free_c) begin
            out_valid_q  <= 1'b1;
            out_filt_q   <= res_filt_q;
            out_idx_q    <= res_idx_q;
            out_done_q   <= res_done_q;
            out_found_q  <= res_found_q;
            out_first_q  <= gap_first_q;
            out_last_q   <= gap_last_q;
            out_tgt_q    <= tgt_q;
            out_trange_q <= trange_q;
            out_ang_q    <= ang_q;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // output ports
  assign out_valid_o       = out_valid_q;
  assign filtered_mm_o     = out_filt_q;
  assign sample_index_o    = out_idx_q;
  assign scan_done_o       = out_done_q;
  assign gap_found_o       = out_found_q;
  assign gap_first_o       = out_first_q;
  assign gap_last_o        = out_last_q;
  assign target_index_o    = out_tgt_q;
  assign target_range_mm_o = out_trange_q;
  assign target_angle_o    = out_ang_q;

  // the best run never falls behind the current run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_len_q >= run_q)
    else $error("best gap length below current run length");

  // gap fields only on the last sample of a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_done_q |-> !out_found_q && out_tgt_q == '0)
    else $error("gap reported on a sample that does not end the scan");

  // the midpoint lies inside the reported gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_found_q |-> out_first_q <= out_tgt_q && out_tgt_q <= out_last_q)
    else $error("target index outside the reported gap");

  // the midpoint lookup only follows a scan end, with the scan state cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TGT |-> sample_count_q == '0 && run_q == '0 && $past(state_q) == S_CLAMP)
    else $error("midpoint lookup without a scan end");

endmodule

`default_nettype wire

// ===== bench/lidar_scan_gap_finder_test.sv =====
// lidar_scan_gap_finder_test: self-checking bench for the lidar scan gap finder
// drives range samples and register writes, predicts every result transaction and compares
// depends on lsgf_pkg and lidar_scan_gap_finder
`timescale 1ns / 100ps

module lidar_scan_gap_finder_test;
  import lsgf_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned PHASES          = 13;
  localparam int unsigned HOLD_PHASE      = 1;
  localparam int unsigned PAUSE_PHASE     = 4;
  localparam int unsigned BIG_PHASE       = 6;
  localparam int unsigned PHASE_ITEMS     = 30;
  localparam int unsigned TAIL_START      = 1013;
  localparam int unsigned RANGE_MAX       = (1 << RANGE_W) - 1;

  typedef struct packed {
    logic [RANGE_W-1:0]        filtered_mm;
    logic [IDX_W-1:0]          sample_index;
    logic                      scan_done;
    logic                      gap_found;
    logic [IDX_W-1:0]          gap_first;
    logic [IDX_W-1:0]          gap_last;
    logic [IDX_W-1:0]          target_index;
    logic [RANGE_W-1:0]        target_range_mm;
    logic signed [ANG_W-1:0]   target_angle;
  } scan_result_t;

  typedef enum logic [1:0] {ROW_CONFIG, ROW_SAMPLE, ROW_KNOWN} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [CFG_DATA_W-1:0]  reg_data;
    logic [RANGE_W-1:0]     sample_mm;
    logic                   invalid;
    scan_result_t           known;
  } stim_row_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic                   in_valid_i      = 1'b0;
  logic [RANGE_W-1:0]     range_mm_i      = '0;
  logic                   range_invalid_i = 1'b0;
  logic                   out_stall_i     = 1'b0;
  logic                   cfg_valid_i     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i      = '0;

  // block outputs
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic [RANGE_W-1:0]     filtered_mm_o;
  logic [IDX_W-1:0]       sample_index_o;
  logic                   scan_done_o;
  logic                   gap_found_o;
  logic [IDX_W-1:0]       gap_first_o;
  logic [IDX_W-1:0]       gap_last_o;
  logic [IDX_W-1:0]       target_index_o;
  logic [RANGE_W-1:0]     target_range_mm_o;
  logic signed [ANG_W-1:0] target_angle_o;
  logic                   cfg_ready_o;

  lidar_scan_gap_finder dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .range_mm_i        (range_mm_i),
    .range_invalid_i   (range_invalid_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .filtered_mm_o     (filtered_mm_o),
    .sample_index_o    (sample_index_o),
    .scan_done_o       (scan_done_o),
    .gap_found_o       (gap_found_o),
    .gap_first_o       (gap_first_o),
    .gap_last_o        (gap_last_o),
    .target_index_o    (target_index_o),
    .target_range_mm_o (target_range_mm_o),
    .target_angle_o    (target_angle_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // predictor copy of the registers
  logic [AWIN_W-1:0]   window_reg;
  logic [RANGE_W-1:0]  clamp_reg;
  logic [RANGE_W-1:0]  level_reg;
  logic [START_W-1:0]  start_reg;
  logic [STEP_W-1:0]   step_reg;
  logic [SLEN_W-1:0]   length_reg;

  // predictor copy of the scan state
  logic [RANGE_W-1:0]  window_taps [MAX_WINDOW];
  logic [RANGE_W-1:0]  filtered_scan [MAX_SCAN];
  int unsigned         scan_pos;
  int unsigned         run_len;
  int unsigned         best_len;
  int unsigned         best_last;

  scan_result_t        expected_results [$];
  stim_row_t           directed_rows [$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         hold_off_asked = 0;
  int unsigned         hold_off_served = 0;
  int unsigned         burst_left = 0;
  int unsigned         run_left = 0;
  bit                  run_high = 1'b0;

  // smooth, clamp and store one sample, track the longest gap, report at scan end
  function automatic scan_result_t filter_and_track(input logic [RANGE_W-1:0] r,
                                                    input logic inv);
    scan_result_t      res;
    int unsigned       eff_len, eff_win, idx, cnt, k, filt, first, tgt;
    longint unsigned   acc;
    longint            ang;
    eff_len = length_reg;
    if (eff_len < 1) eff_len = 1;
    if (eff_len > MAX_SCAN) eff_len = MAX_SCAN;
    eff_win = window_reg;
    if (eff_win > MAX_WINDOW) eff_win = MAX_WINDOW;
    if (eff_len < eff_win) eff_win = 0;
    idx = scan_pos;
    if (idx >= MAX_SCAN) idx = MAX_SCAN - 1;

    // invalid samples enter the window as the clamp limit
    for (k = MAX_WINDOW - 1; k > 0; k--) window_taps[k] = window_taps[k-1];
    window_taps[0] = inv ? clamp_reg : r;

    if (eff_win == 0) begin
      filt = r;
    end else begin
      cnt = (idx + 1 < eff_win) ? idx + 1 : eff_win;
      acc = 0;
      for (k = 0; k < cnt; k++) acc += window_taps[k];
      filt = int'(acc / cnt);
    end
    if (inv || filt > clamp_reg) filt = clamp_reg;
    filtered_scan[idx] = filt[RANGE_W-1:0];

    // longest run above the gap level, earliest wins on a tie
    if (filt > level_reg) begin
      run_len++;
      if (run_len > best_len) begin
        best_len  = run_len;
        best_last = idx;
      end
    end else begin
      run_len = 0;
    end

    res = '0;
    res.filtered_mm  = filt[RANGE_W-1:0];
    res.sample_index = idx[IDX_W-1:0];
    res.scan_done    = (idx >= eff_len - 1);
    if (res.scan_done) begin
      if (best_len > 0) begin
        first = best_last + 1 - best_len;
        tgt   = (first + best_last) >> 1;
        ang   = longint'($signed(start_reg)) + longint'(tgt) * longint'(step_reg);
        if (ang > ANG_MAX_I) ang = ANG_MAX_I;
        if (ang < -ANG_MAX_I - 1) ang = -ANG_MAX_I - 1;
        res.gap_found       = 1'b1;
        res.gap_first       = first[IDX_W-1:0];
        res.gap_last        = best_last[IDX_W-1:0];
        res.target_index    = tgt[IDX_W-1:0];
        res.target_range_mm = filtered_scan[tgt];
        res.target_angle    = ang[ANG_W-1:0];
      end
      scan_pos  = 0;
      run_len   = 0;
      best_len  = 0;
      best_last = 0;
    end else begin
      scan_pos = idx + 1;
    end
    return res;
  endfunction

  function automatic string show_result(scan_result_t r);
    return $sformatf("filt=%0d idx=%0d done=%0b found=%0b first=%0d last=%0d tgt=%0d rng=%0d ang=%0d",
                     r.filtered_mm, r.sample_index, r.scan_done, r.gap_found, r.gap_first,
                     r.gap_last, r.target_index, r.target_range_mm, r.target_angle);
  endfunction

  function automatic string diff_fields(scan_result_t want, scan_result_t got);
    string s;
    s = "";
    if (want.filtered_mm     !== got.filtered_mm)     s = {s, " filtered_mm"};
    if (want.sample_index    !== got.sample_index)    s = {s, " sample_index"};
    if (want.scan_done       !== got.scan_done)       s = {s, " scan_done"};
    if (want.gap_found       !== got.gap_found)       s = {s, " gap_found"};
    if (want.gap_first       !== got.gap_first)       s = {s, " gap_first"};
    if (want.gap_last        !== got.gap_last)        s = {s, " gap_last"};
    if (want.target_index    !== got.target_index)    s = {s, " target_index"};
    if (want.target_range_mm !== got.target_range_mm) s = {s, " target_range_mm"};
    if (want.target_angle    !== got.target_angle)    s = {s, " target_angle"};
    return s;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // directed table rows
  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
    stim_row_t row;
    row = '{kind: ROW_CONFIG, reg_index: idx, reg_data: CFG_DATA_W'(value),
            sample_mm: '0, invalid: 1'b0, known: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_sample(input int unsigned r, input logic inv);
    stim_row_t row;
    row = '{kind: ROW_SAMPLE, reg_index: '0, reg_data: '0,
            sample_mm: RANGE_W'(r), invalid: inv, known: '0};
    directed_rows.push_back(row);
  endfunction

  // gap fields stay zero on these rows
  function automatic void add_known(input int unsigned r, input logic inv,
                                    input int unsigned filt, input int unsigned idx,
                                    input logic done);
    stim_row_t row;
    row = '{kind: ROW_KNOWN, reg_index: '0, reg_data: '0,
            sample_mm: RANGE_W'(r), invalid: inv, known: '0};
    row.known.filtered_mm  = RANGE_W'(filt);
    row.known.sample_index = IDX_W'(idx);
    row.known.scan_done    = done;
    directed_rows.push_back(row);
  endfunction

  // one register write transaction, predictor follows at acceptance
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_AVG_WINDOW:  window_reg = data[AWIN_W-1:0];
      CFG_CLAMP_LIMIT: clamp_reg  = data[RANGE_W-1:0];
      CFG_GAP_LEVEL:   level_reg  = data[RANGE_W-1:0];
      CFG_ANGLE_START: start_reg  = data[START_W-1:0];
      CFG_ANGLE_STEP:  step_reg   = data[STEP_W-1:0];
      CFG_SCAN_LENGTH: length_reg = data[SLEN_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one sample transaction and hold it until accepted
  task automatic offer_sample(input logic [RANGE_W-1:0] r, input logic inv,
                              input bit typed, input scan_result_t known);
    scan_result_t predicted;
    in_valid_i      <= 1'b1;
    range_mm_i      <= r;
    range_invalid_i <= inv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = filter_and_track(r, inv);
    expected_results.push_back(typed ? known : predicted);
  endtask

  // bursts of back-to-back samples separated by random gaps
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_valid_i      <= 1'b0;
        range_mm_i      <= RANGE_W'($urandom);
        range_invalid_i <= 1'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // runs of samples above or below the gap level, with noise and invalid beams
  task automatic pick_sample(input bit tail, output logic [RANGE_W-1:0] r, output logic inv);
    int unsigned v;
    inv = 1'b0;
    if (tail) begin
      v = (scan_pos < TAIL_START) ? $urandom_range(0, 3000) : $urandom_range(50000, RANGE_MAX);
    end else begin
      if (run_left == 0) begin
        run_high = 1'($urandom_range(0, 1));
        run_left = $urandom_range(1, 10);
      end
      run_left--;
      case ($urandom_range(0, 9))
        0: begin
          v   = $urandom_range(0, RANGE_MAX);
          inv = 1'b1;
        end
        1: v = $urandom_range(0, RANGE_MAX);
        default: begin
          if (run_high) v = level_reg + $urandom_range(1, 20000);
          else if (level_reg > 20000) v = level_reg - $urandom_range(0, 20000);
          else v = $urandom_range(0, level_reg);
          if (v > RANGE_MAX) v = RANGE_MAX;
        end
      endcase
    end
    r = RANGE_W'(v);
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin : receiver_pattern
    int unsigned span, style;
    forever begin
      if (hold_off_asked != hold_off_served) begin
        hold_off_served++;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(1, 40);
        repeat (span) begin
          case (style)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 3) == 0);
            2: out_stall_i <= 1'($urandom_range(0, 1));
            default: out_stall_i <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // compare every accepted result transaction with the oldest expectation
  always @(posedge clk_i) begin
    scan_result_t got, want;
    string differ;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {filtered_mm_o, sample_index_o, scan_done_o, gap_found_o, gap_first_o,
             gap_last_o, target_index_o, target_range_mm_o, target_angle_o};
      if (expected_results.size() == 0) begin
        note_mismatch({"result with nothing expected: ", show_result(got)});
      end else begin
        want   = expected_results.pop_front();
        differ = diff_fields(want, got);
        if (differ != "")
          note_mismatch({"fields", differ, "\n  expected ", show_result(want),
                         "\n  actual   ", show_result(got)});
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t          row;
    int unsigned        phase, n, i, win, clamp, lvl, step, len;
    int                 start;
    bit                 tail;
    logic [RANGE_W-1:0] r;
    logic               inv;

    // predictor starts from the reset state
    window_reg = AVG_WINDOW_RST;
    clamp_reg  = CLAMP_LIMIT_RST;
    level_reg  = GAP_LEVEL_RST;
    start_reg  = ANGLE_START_RST;
    step_reg   = ANGLE_STEP_RST;
    length_reg = SCAN_LENGTH_RST;
    foreach (window_taps[k]) window_taps[k] = '0;
    foreach (filtered_scan[k]) filtered_scan[k] = '0;
    scan_pos  = 0;
    run_len   = 0;
    best_len  = 0;
    best_last = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset: raw pass-through and clamp to the reset limit
    add_known(0, 1'b0, 0, 0, 1'b0);
    add_known(RANGE_MAX, 1'b0, 100000, 1, 1'b0);
    add_known(5, 1'b1, 100000, 2, 1'b0);
    // scan length lowered below the current position ends the scan
    add_cfg(CFG_SCAN_LENGTH, 2);
    add_sample(50000, 1'b0);
    // length zero acts as one; a sample equal to the level is no gap
    add_cfg(CFG_SCAN_LENGTH, 0);
    add_known(3000, 1'b0, 3000, 0, 1'b1);
    add_sample(3001, 1'b0);
    // zero clamp limit
    add_cfg(CFG_CLAMP_LIMIT, 0);
    add_known(77, 1'b0, 0, 0, 1'b1);
    // full window on a short scan passes raw, widest clamp, lowest level
    add_cfg(CFG_CLAMP_LIMIT, RANGE_MAX);
    add_cfg(CFG_GAP_LEVEL, 0);
    add_cfg(CFG_AVG_WINDOW, MAX_WINDOW);
    add_cfg(CFG_SCAN_LENGTH, 6);
    add_cfg(CFG_ANGLE_START, 31416);
    add_cfg(CFG_ANGLE_STEP, 1000);
    add_sample(RANGE_MAX, 1'b0);
    add_sample(RANGE_MAX, 1'b0);
    add_sample(RANGE_MAX, 1'b0);
    add_sample(5, 1'b1);
    add_sample(0, 1'b0);
    add_sample(1, 1'b0);
    // oversized window on a short scan passes raw; equal gaps, earliest wins
    add_cfg(CFG_AVG_WINDOW, 31);
    add_cfg(CFG_SCAN_LENGTH, 5);
    add_cfg(CFG_GAP_LEVEL, 3000);
    add_cfg(CFG_CLAMP_LIMIT, 100000);
    add_cfg(CFG_ANGLE_START, -31416);
    add_cfg(CFG_ANGLE_STEP, 0);
    add_sample(5000, 1'b0);
    add_sample(0, 1'b0);
    add_sample(5000, 1'b0);
    add_sample(0, 1'b0);
    add_sample(5000, 1'b0);
    // top gap level: nothing can exceed it
    add_cfg(CFG_AVG_WINDOW, 0);
    add_cfg(CFG_SCAN_LENGTH, 1);
    add_cfg(CFG_GAP_LEVEL, RANGE_MAX);
    add_cfg(CFG_CLAMP_LIMIT, RANGE_MAX);
    add_known(RANGE_MAX, 1'b0, RANGE_MAX, 0, 1'b1);
    // single-sample window, oversized scan length
    add_cfg(CFG_AVG_WINDOW, 1);
    add_cfg(CFG_GAP_LEVEL, 0);
    add_cfg(CFG_SCAN_LENGTH, 2047);
    add_sample(7, 1'b0);

    foreach (directed_rows[j]) begin
      row = directed_rows[j];
      case (row.kind)
        ROW_CONFIG: begin
          wait_idle();
          write_register(row.reg_index, row.reg_data);
        end
        ROW_SAMPLE: begin
          offer_sample(row.sample_mm, row.invalid, 1'b0, '0);
          pace_sender();
        end
        default: begin
          offer_sample(row.sample_mm, row.invalid, 1'b1, row.known);
          pace_sender();
        end
      endcase
    end

    // random phases, each with its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      tail = (phase == BIG_PHASE);
      if (tail) begin
        // one full scan with the gap at its far end, so the angle saturates
        win   = 0;
        clamp = 100000;
        lvl   = 3000;
        start = 31416;
        step  = 1000;
        len   = MAX_SCAN;
      end else begin
        case ($urandom_range(0, 5))
          0: win = 0;
          1: win = 1;
          2: win = MAX_WINDOW;
          3: win = $urandom_range(MAX_WINDOW + 1, 31);
          default: win = $urandom_range(2, MAX_WINDOW - 1);
        endcase
        case ($urandom_range(0, 3))
          0: clamp = RANGE_MAX;
          1: clamp = $urandom_range(0, RANGE_MAX);
          default: clamp = $urandom_range(20000, RANGE_MAX);
        endcase
        case ($urandom_range(0, 5))
          0: lvl = 0;
          1: lvl = RANGE_MAX;
          default: lvl = $urandom_range(0, clamp);
        endcase
        start = int'($urandom_range(0, 62832)) - 31416;
        step  = $urandom_range(0, 1000);
        case ($urandom_range(0, 7))
          0: len = 0;
          1: len = 2047;
          2: len = $urandom_range(25, 64);
          default: len = $urandom_range(1, 24);
        endcase
      end
      write_register(CFG_AVG_WINDOW, CFG_DATA_W'(win));
      write_register(CFG_CLAMP_LIMIT, CFG_DATA_W'(clamp));
      write_register(CFG_GAP_LEVEL, CFG_DATA_W'(lvl));
      write_register(CFG_ANGLE_START, CFG_DATA_W'(start));
      write_register(CFG_ANGLE_STEP, CFG_DATA_W'(step));
      write_register(CFG_SCAN_LENGTH, CFG_DATA_W'(len));

      n = tail ? MAX_SCAN - scan_pos : PHASE_ITEMS;
      if (phase == HOLD_PHASE) hold_off_asked++;
      for (i = 0; i < n; i++) begin
        if (phase == PAUSE_PHASE && i == n / 2) wait_idle();
        pick_sample(tail, r, inv);
        offer_sample(r, inv, 1'b0, '0);
        pace_sender();
      end
    end

    // drain and give the verdict
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
